>>> src/sva_pkg.sv
package sva_pkg;
    localparam int VOICES = 8;

    localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
    localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
    localparam logic [1:0] REQ_PEDAL    = 2'd2;
    localparam logic [1:0] REQ_TICK     = 2'd3;

    localparam logic [1:0] MODE_MONO = 2'd0;
    localparam logic [1:0] MODE_POLY = 2'd1;
    localparam logic [1:0] MODE_ARP  = 2'd2;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_STOP    = 2'd2;
    localparam logic [1:0] ACT_RESTART = 2'd3;

    localparam logic [1:0] GATE_NONE = 2'd0;
    localparam logic [1:0] GATE_ON   = 2'd1;
    localparam logic [1:0] GATE_OFF  = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] midi_note;
        logic       pedal_down;
    } t_req;

    typedef struct packed {
        logic [2:0] voice_id;
        logic [6:0] voice_note;
        logic [1:0] voice_action;
        logic [1:0] envelope_gate;
        logic       last_result;
    } t_cmd;
endpackage

>>> src/sva_if.sv
interface sva_req_if;
    import sva_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sva_cmd_if;
    import sva_pkg::*;
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sva_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/synth_voice_allocator.sv
// Voice allocator for a polyphonic synthesizer.
// Channels: i_req (sink) takes one request beat: type, note, pedal state.
// o_cmd (source) gives voice command beats; the final beat of a request
// has last_result set. A request may give no beat at all.
// i_cfg (sink) writes play_mode; its ready is always high; write only while
// the block is idle.
// Timing: the block holds one request at a time and ready is low while a
// request is in work. A sequencer walks the sounding list one entry per
// cycle through a single shared compare unit, and list removal, insertion
// sort and queue pop each move one entry per cycle. A pedal press or an
// ignored tick returns straight to idle, a monophonic note on passes the
// mono state, and a polyphonic note on passes scan, queue pop where
// needed, and sort. A tick wraps its position by one subtract at a time,
// then gives its two beats.
// Reset: sounding list empty, free queue holds voices 0..VOICES-1 with
// voice 0 at the head, all voice flags clear, mode monophonic.
// Stall: a command beat waits in the output register until taken; the
// sequencer halts at its next beat meanwhile, so no beat is lost or repeated.
module synth_voice_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sva_req_if.sink    i_req,
    sva_cmd_if.source  o_cmd,
    sva_cfg_if.sink    i_cfg
);
    import sva_pkg::*;

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);
    localparam logic [CW-1:0] NV = CW'(VOICES);

    localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_DEC = 4'd2,
        S_POP = 4'd3, S_SORT = 4'd4, S_REM = 4'd5, S_EMIT = 4'd6,
        S_PED = 4'd7, S_MONO = 4'd8, S_ARP = 4'd9, S_DONE = 4'd10;

    logic [3:0]    r_st;
    logic [1:0]    r_mode;
    t_req          r_req;
    logic [2:0]    r_vl [VOICES];
    logic [6:0]    r_nl [VOICES];
    logic [CW-1:0] r_scnt;
    logic [2:0]    r_fq [VOICES];
    logic [CW-1:0] r_fcnt;
    logic [6:0]    r_cur [VOICES];
    logic [VOICES-1:0] r_held, r_snd;
    logic          r_sus;
    logic [IW-1:0] r_arp;
    logic [CW-1:0] r_i, r_j;
    logic          r_fnd;
    logic [2:0]    r_fv;
    logic [CW-1:0] r_fi;
    logic [CW-1:0] r_ncnt;
    logic          r_ovld;
    t_cmd          r_out;
    // held command beat: note-on result, arpeggiator restart, last pedal stop
    logic          r_pend;
    t_cmd          r_pcmd;

    assign i_req.ready = (r_st == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_cmd.valid = r_ovld;
    assign o_cmd.data  = r_out;

    logic          out_free;
    logic [IW-1:0] ii, jj;
    logic [2:0]    sv;
    logic [IW-1:0] svi;
    logic          cmp_eq;
    assign out_free = !r_ovld || o_cmd.ready;
    assign ii  = r_i[IW-1:0];
    assign jj  = r_j[IW-1:0];
    assign sv  = r_vl[ii];
    assign svi = sv[IW-1:0];
    // shared compare unit: note of the listed voice against the request
    assign cmp_eq = ({1'b0, sv} < 4'(VOICES)) && (r_cur[svi] == r_req.midi_note);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_mode <= MODE_MONO; r_scnt <= '0; r_fcnt <= NV;
            r_held <= '0; r_snd <= '0; r_sus <= 1'b0; r_arp <= '0;
            r_ovld <= 1'b0; r_pend <= 1'b0; r_j <= '0;
            for (int k = 0; k < VOICES; k++) begin
                r_fq[k] <= 3'(k); r_cur[k] <= '0; r_vl[k] <= '0;
            end
        end else begin
            if (i_cfg.valid) r_mode <= i_cfg.data;
            if (r_ovld && o_cmd.ready) r_ovld <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_req.valid) begin
                    r_req <= i_req.data; r_fnd <= 1'b0; r_ncnt <= '0;
                    r_i <= (i_req.data.req_type == REQ_TICK) ? CW'(r_arp) + CW'(1) : '0;
                    unique case (i_req.data.req_type)
                        REQ_NOTE_ON: r_st <= (r_mode == MODE_MONO) ? S_MONO : S_SCAN;
                        REQ_NOTE_OFF: r_st <= S_SCAN;
                        REQ_PEDAL: begin
                            r_sus <= i_req.data.pedal_down;
                            r_st <= i_req.data.pedal_down ? S_IDLE : S_PED;
                        end
                        default: r_st <= (r_mode == MODE_ARP && r_scnt != 0) ? S_ARP
                                                                               : S_IDLE;
                    endcase
                end
                S_MONO: if (out_free) begin
                    r_out <= '{3'd0, r_req.midi_note, ACT_START,
                               (r_scnt == 0) ? GATE_ON : GATE_NONE, 1'b1};
                    r_ovld <= 1'b1;
                    r_cur[0] <= r_req.midi_note; r_held[0] <= 1'b1; r_snd[0] <= 1'b1;
                    r_st <= S_IDLE;
                end
                // walk the list one entry a cycle
                S_SCAN: begin
                    if (r_i < r_scnt) begin
                        if (cmp_eq) begin
                            r_fnd <= 1'b1; r_fv <= sv; r_fi <= r_i;
                        end
                        if (cmp_eq && r_req.req_type == REQ_NOTE_OFF) r_st <= S_DEC;
                        else r_i <= r_i + 1'b1;
                    end else r_st <= S_DEC;
                end
                S_DEC: begin
                    if (r_req.req_type == REQ_NOTE_OFF) begin
                        if (r_fnd) begin
                            r_held[r_fv[IW-1:0]] <= 1'b0;
                            if (!r_sus) begin
                                r_snd[r_fv[IW-1:0]] <= 1'b0;
                                r_i <= r_fi; r_st <= S_REM;
                            end else r_st <= S_EMIT;
                        end else r_st <= S_EMIT;
                    end else if (r_fnd) begin
                        r_pcmd <= '{r_fv, r_req.midi_note, ACT_RESTART, GATE_NONE, 1'b1};
                        r_cur[r_fv[IW-1:0]] <= r_req.midi_note;
                        r_held[r_fv[IW-1:0]] <= 1'b1; r_snd[r_fv[IW-1:0]] <= 1'b1;
                        r_i <= CW'(1); r_st <= S_SORT;
                        r_ncnt <= CW'(1);
                    end else if (r_fcnt != 0) begin
                        r_fv <= r_fq[0]; r_i <= '0; r_st <= S_POP;
                    end else if (r_scnt != 0) begin
                        r_fv <= r_vl[0]; r_nl[0] <= r_req.midi_note;
                        r_pcmd <= '{r_vl[0], r_req.midi_note, ACT_START, GATE_NONE, 1'b1};
                        r_cur[r_vl[0][IW-1:0]] <= r_req.midi_note;
                        r_held[r_vl[0][IW-1:0]] <= 1'b1; r_snd[r_vl[0][IW-1:0]] <= 1'b1;
                        r_i <= CW'(1); r_ncnt <= CW'(1); r_st <= S_SORT;
                    end else r_st <= S_IDLE;
                end
                // shift the free queue down one entry a cycle
                S_POP: begin
                    if (r_i + 1'b1 < r_fcnt) begin
                        r_fq[ii] <= r_fq[IW'(r_i + 1'b1)]; r_i <= r_i + 1'b1;
                    end else begin
                        r_fcnt <= r_fcnt - 1'b1;
                        r_vl[r_scnt[IW-1:0]] <= r_fv;
                        r_nl[r_scnt[IW-1:0]] <= r_req.midi_note;
                        r_scnt <= r_scnt + 1'b1;
                        r_pcmd <= '{r_fv, r_req.midi_note, ACT_START, GATE_NONE, 1'b1};
                        r_cur[r_fv[IW-1:0]] <= r_req.midi_note;
                        r_held[r_fv[IW-1:0]] <= 1'b1; r_snd[r_fv[IW-1:0]] <= 1'b1;
                        r_i <= CW'(1); r_ncnt <= CW'(1); r_st <= S_SORT;
                    end
                end
                // insertion sort: one swap a cycle; r_j walks down
                S_SORT: begin
                    if (r_j == '0 || r_i >= r_scnt) begin
                        // r_j==0 in a fresh pass means start with j=i
                        if (r_i >= r_scnt) r_st <= S_EMIT;
                        else r_j <= r_i;
                    end else if (r_nl[IW'(r_j - 1'b1)] > r_nl[jj]) begin
                        r_nl[jj] <= r_nl[IW'(r_j - 1'b1)];
                        r_vl[jj] <= r_vl[IW'(r_j - 1'b1)];
                        r_nl[IW'(r_j - 1'b1)] <= r_nl[jj];
                        r_vl[IW'(r_j - 1'b1)] <= r_vl[jj];
                        r_j <= r_j - 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1; r_j <= '0;
                    end
                end
                // remove list entry r_i, one shift a cycle, then free the voice
                S_REM: begin
                    if (r_i + 1'b1 < r_scnt) begin
                        r_vl[ii] <= r_vl[IW'(r_i + 1'b1)];
                        r_nl[ii] <= r_nl[IW'(r_i + 1'b1)];
                        r_i <= r_i + 1'b1;
                    end else if (out_free) begin
                        r_scnt <= r_scnt - 1'b1;
                        if (r_fcnt < NV) begin
                            r_fq[r_fcnt[IW-1:0]] <= r_fv; r_fcnt <= r_fcnt + 1'b1;
                        end
                        r_ncnt <= r_ncnt + 1'b1;
                        if (r_req.req_type == REQ_PEDAL) begin
                            // hold this stop beat back, release the one held before it
                            if (r_pend) begin
                                r_out <= '{r_pcmd.voice_id, r_pcmd.voice_note, ACT_STOP,
                                           GATE_NONE, 1'b0};
                                r_ovld <= 1'b1;
                            end
                            r_pcmd <= '{r_fv, r_cur[r_fv[IW-1:0]], ACT_STOP, GATE_NONE, 1'b1};
                            r_pend <= 1'b1;
                            r_i <= r_fi; r_st <= S_PED;
                        end else begin
                            r_out <= '{r_fv, r_cur[r_fv[IW-1:0]], ACT_STOP, GATE_NONE,
                                       !(r_mode == MODE_MONO && r_scnt == CW'(1))};
                            r_ovld <= 1'b1; r_st <= S_EMIT;
                        end
                    end
                end
                // pedal release: look for the next sounding voice with key up
                S_PED: begin
                    if (r_i < r_scnt && r_ncnt < CW'(VOICES < 8 ? VOICES : 8)) begin
                        if (r_snd[svi] && !r_held[svi]) begin
                            r_fv <= sv; r_fi <= r_i; r_snd[svi] <= 1'b0; r_st <= S_REM;
                        end else r_i <= r_i + 1'b1;
                    end else if (out_free) begin
                        // flush the held stop beat as the final one in S_EMIT
                        r_st <= S_EMIT;
                    end
                end
                S_EMIT: if (out_free) begin
                    if (r_req.req_type == REQ_NOTE_ON) begin
                        if (r_ncnt != 0) begin
                            r_out <= r_pcmd; r_ovld <= 1'b1;
                        end
                        r_st <= S_IDLE;
                    end else if (r_req.req_type == REQ_NOTE_OFF && r_mode == MODE_MONO
                                 && r_scnt == 0) begin
                        r_out <= '{3'd0, r_cur[0], ACT_NONE, GATE_OFF, 1'b1};
                        r_ovld <= 1'b1; r_st <= S_IDLE;
                    end else if (r_req.req_type == REQ_PEDAL && r_ncnt != 0) begin
                        r_out <= r_pcmd; r_ovld <= r_pend; r_pend <= 1'b0;
                        r_st <= S_IDLE;
                    end else begin
                        r_ovld <= r_pend; r_out <= r_pcmd; r_pend <= 1'b0;
                        r_st <= S_IDLE;
                    end
                end
                S_ARP: begin
                    if (!r_pend && r_i >= r_scnt) begin
                        // wrap the advanced position, one subtract a cycle
                        r_i <= r_i - r_scnt;
                    end else if (out_free) begin
                        if (!r_pend) begin
                            logic [CW-1:0] nxt;
                            nxt = (r_i + 1'b1 >= r_scnt) ? '0 : r_i + 1'b1;
                            r_arp <= ii;
                            r_out <= '{r_vl[ii], r_cur[r_vl[ii][IW-1:0]],
                                       ACT_STOP, GATE_NONE, 1'b0};
                            r_ovld <= 1'b1;
                            r_snd[r_vl[ii][IW-1:0]] <= 1'b0;
                            r_pcmd <= '{r_vl[nxt[IW-1:0]], 7'd0, ACT_RESTART, GATE_NONE,
                                        1'b1};
                            r_fv <= r_vl[nxt[IW-1:0]];
                            r_pend <= 1'b1;
                        end else begin
                            r_out <= '{r_fv, r_cur[r_fv[IW-1:0]], ACT_RESTART, GATE_NONE,
                                       1'b1};
                            r_snd[r_fv[IW-1:0]] <= 1'b1;
                            r_ovld <= 1'b1; r_pend <= 1'b0; r_st <= S_IDLE;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

>>> src/sva_checker.sv
module sva_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic [1:0] cmd_action
);
    // hold an unaccepted command beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid) else $error("cmd dropped");
    // keep the action of a stalled beat steady
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_valid && !cmd_ready |=> $stable(cmd_action)) else $error("cmd changed");
    // reset leaves output idle
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !cmd_valid)
        else $error("valid after reset");
endmodule

bind synth_voice_allocator sva_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .cmd_valid(o_cmd.valid), .cmd_ready(o_cmd.ready),
    .cmd_action(o_cmd.data.voice_action)
);
